[rtl/trm_pkg.sv]
// Package for the register machine execute block: widths and opcodes.
// No dependencies.
`timescale 1ns / 1ps
package trm_pkg;
	localparam int NumRegs = 10;
	localparam int DataWidth = 32;
	localparam int PcWidth = 8;
	localparam int RegIdxWidth = 4;
	localparam int CntWidth = $clog2(DataWidth + 1);

	typedef enum logic [3:0] {
		FN_HALT = 4'd0, FN_ADD = 4'd1, FN_SUB = 4'd2, FN_MUL = 4'd3,
		FN_DIV = 4'd4, FN_MOV = 4'd5, FN_LDI = 4'd6, FN_SHOW = 4'd7,
		FN_CLR = 4'd8, FN_JMP = 4'd9, FN_BEQ = 4'd10, FN_BNE = 4'd11,
		FN_SLT = 4'd12
	} func_t;

	localparam logic [1:0] KIND_REG = 2'd1;
	localparam logic [1:0] KIND_IMM = 2'd2;

	typedef struct packed {
		logic start;
		logic is_div;
	} mdu_ctl_t;
endpackage

[rtl/trm_mdu.sv]
// Bit-serial multiply / signed divide unit, one bit per cycle.
// Depends on trm_pkg.
`timescale 1ns / 1ps
module trm_mdu import trm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mdu_ctl_t             ctl,
	input  logic [DataWidth-1:0] op_a,
	input  logic [DataWidth-1:0] op_b,
	output logic                 done,
	output logic [DataWidth-1:0] result
);
	logic [DataWidth-1:0] acc_q, sh_q, opb_q;
	logic [CntWidth-1:0]  cnt_q;
	logic                 busy_q, div_q, neg_q;
	logic [DataWidth:0]   trial;
	logic [DataWidth-1:0] rem_sh;

	assign rem_sh = {acc_q[DataWidth-2:0], sh_q[DataWidth-1]};
	assign trial = {1'b0, rem_sh} - {1'b0, opb_q};
	assign done = busy_q && (cnt_q == CntWidth'(0));
	assign result = !div_q ? acc_q : (neg_q ? (~sh_q + 1'b1) : sh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntWidth'(DataWidth);
			div_q  <= ctl.is_div;
			neg_q  <= op_a[DataWidth-1] ^ op_b[DataWidth-1];
			acc_q  <= '0;
			if (ctl.is_div) begin
				sh_q  <= op_a[DataWidth-1] ? (~op_a + 1'b1) : op_a;
				opb_q <= op_b[DataWidth-1] ? (~op_b + 1'b1) : op_b;
			end else begin
				sh_q  <= op_a;
				opb_q <= op_b;
			end
		end else if (busy_q) begin
			if (cnt_q == CntWidth'(0)) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
				if (div_q) begin
					// restoring divide: quotient bits shift into sh_q
					acc_q <= trial[DataWidth] ? rem_sh : trial[DataWidth-1:0];
					sh_q  <= {sh_q[DataWidth-2:0], ~trial[DataWidth]};
				end else begin
					// add-shift, multiplier MSB first
					acc_q <= {acc_q[DataWidth-2:0], 1'b0} +
						(sh_q[DataWidth-1] ? opb_q : '0);
					sh_q  <= {sh_q[DataWidth-2:0], 1'b0};
				end
			end
		end
	end
endmodule

[rtl/tiny_register_machine_execute.sv]
// Top level of the register machine execute block.
// Depends on trm_pkg and trm_mdu.
`timescale 1ns / 1ps
// Operations are latched on accept, executed in ST_EXEC and their result
// registered; MUL and DIV by a nonzero divisor wait in ST_WAIT for the
// bit-serial multiply/divide unit (one bit a cycle). One at a time: the next
// is accepted once the result register is empty or being taken.
// Reset: arst_n clears control state and the ten registers to zero.
module tiny_register_machine_execute import trm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [3:0]             func,
	input  logic [RegIdxWidth-1:0] dest_reg,
	input  logic [1:0]             src_a_kind,
	input  logic [RegIdxWidth-1:0] src_a_reg,
	input  logic signed [31:0]     src_a_imm,
	input  logic [1:0]             src_b_kind,
	input  logic [RegIdxWidth-1:0] src_b_reg,
	input  logic signed [31:0]     src_b_imm,
	input  logic [PcWidth-1:0]     branch_target,
	input  logic [PcWidth-1:0]     cur_pc,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PcWidth-1:0]     next_pc,
	output logic                   halt,
	output logic                   reg_written,
	output logic [RegIdxWidth-1:0] written_reg,
	output logic signed [31:0]     written_value,
	output logic signed [31:0]     shown_value,
	output logic                   div_by_zero
);
	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT} state_t;

	state_t state_q;
	logic [DataWidth-1:0] rf_q [NumRegs];
	// latched transaction
	logic [3:0]             fn_q;
	logic [RegIdxWidth-1:0] dst_q, ra_q, rb_q;
	logic [1:0]             ka_q, kb_q;
	logic [31:0]            ia_q, ib_q;
	logic [PcWidth-1:0]     tgt_q, pc_q;

	logic out_busy;
	assign out_busy = out_valid && out_stall;
	assign in_stall = (state_q != ST_IDLE) || out_busy;

	function automatic logic [DataWidth-1:0] rd(
		input logic [DataWidth-1:0] rf [NumRegs], input logic [RegIdxWidth-1:0] i);
		return (32'(i) < NumRegs) ? rf[i] : '0;
	endfunction

	logic [DataWidth-1:0] a, b, ca, cb, wval;
	logic [PcWidth-1:0]   nxt, pc1;
	logic                 want_wr, hlt, dz, need_mdu;
	logic [DataWidth-1:0] shown;

	always_comb begin
		a = rd(rf_q, ra_q);
		b = rd(rf_q, rb_q);
		ca = (ka_q == KIND_REG) ? a : (ka_q == KIND_IMM) ? ia_q : '0;
		cb = (kb_q == KIND_REG) ? b : (kb_q == KIND_IMM) ? ib_q : '0;
		pc1 = pc_q + 1'b1;
		nxt = pc1;
		wval = '0;
		want_wr = 1'b0;
		hlt = 1'b0;
		dz = 1'b0;
		shown = '0;
		need_mdu = 1'b0;
		case (fn_q)
			FN_HALT: begin hlt = 1'b1; nxt = pc_q; end
			FN_ADD:  begin wval = a + b; want_wr = 1'b1; end
			FN_SUB:  begin wval = a - b; want_wr = 1'b1; end
			FN_MUL:  need_mdu = 1'b1;
			FN_DIV:  begin if (b == '0) dz = 1'b1; else need_mdu = 1'b1; end
			FN_MOV:  begin wval = a; want_wr = 1'b1; end
			FN_LDI:  begin wval = ia_q; want_wr = 1'b1; end
			FN_SHOW: shown = rd(rf_q, dst_q);
			FN_JMP:  nxt = (tgt_q != pc_q) ? tgt_q : pc1;
			FN_BEQ:  nxt = ((ca == cb) && tgt_q != pc_q) ? tgt_q : pc1;
			FN_BNE:  nxt = ((ca != cb) && tgt_q != pc_q) ? tgt_q : pc1;
			FN_SLT:  begin
				wval = DataWidth'(($signed(ca) < $signed(cb)));
				want_wr = 1'b1;
			end
			default: ;
		endcase
	end

	mdu_ctl_t mctl;
	logic mdone;
	logic [DataWidth-1:0] mres;
	assign mctl.start = (state_q == ST_EXEC) && need_mdu;
	assign mctl.is_div = (fn_q == FN_DIV);

	trm_mdu u_mdu (
		.clk(clk), .arst_n(arst_n), .ctl(mctl),
		.op_a(a), .op_b(b), .done(mdone), .result(mres)
	);

	logic dst_ok;
	assign dst_ok = 32'(dst_q) < NumRegs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						fn_q <= func; dst_q <= dest_reg;
						ka_q <= src_a_kind; ra_q <= src_a_reg; ia_q <= src_a_imm;
						kb_q <= src_b_kind; rb_q <= src_b_reg; ib_q <= src_b_imm;
						tgt_q <= branch_target; pc_q <= cur_pc;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (need_mdu) begin
						state_q <= ST_WAIT;
					end else begin
						if (fn_q == FN_CLR)
							for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
						if (want_wr && dst_ok) rf_q[dst_q] <= wval;
						next_pc <= nxt; halt <= hlt; div_by_zero <= dz;
						shown_value <= shown;
						reg_written <= want_wr && dst_ok;
						written_reg <= (want_wr && dst_ok) ? dst_q : '0;
						written_value <= (want_wr && dst_ok) ? wval : '0;
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_WAIT: begin
					if (mdone) begin
						if (dst_ok) rf_q[dst_q] <= mres;
						next_pc <= pc1; halt <= 1'b0; div_by_zero <= 1'b0;
						shown_value <= '0;
						reg_written <= dst_ok;
						written_reg <= dst_ok ? dst_q : '0;
						written_value <= dst_ok ? mres : '0;
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/trm_checker.sv]
// Port-level checker for the execute block, bound to the top level.
// Depends on trm_pkg.
`timescale 1ns / 1ps
module trm_checker import trm_pkg::*; (
	input logic clk, arst_n, in_valid, in_stall, out_valid, out_stall,
	input logic halt, reg_written, div_by_zero,
	input logic [RegIdxWidth-1:0] written_reg,
	input logic signed [31:0] written_value
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second transaction taken");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reg_written && div_by_zero) && !(reg_written && halt))
		else $error("conflicting flags");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_written |-> written_reg == '0 && written_value == '0)
		else $error("write fields not cleared");
endmodule

bind tiny_register_machine_execute trm_checker u_chk (.*);
